[sv/skyline_rect_packer_macros.svh]
// Assertion macros used by the skyline packer checker.
`ifndef SKYLINE_RECT_PACKER_MACROS_SVH
`define SKYLINE_RECT_PACKER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRP_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define SRP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

[sv/srp_pkg.sv]
// Shared types, constants and a helper function of the skyline rectangle packer.
package srp_pkg;

   localparam int COORD_W = 13;
   localparam int SIZE_W = 12;
   localparam int PROD_W = 24;
   localparam int AREA_W = 25;
   localparam int PAD_W = 2;

   localparam int DEF_MIN_PAGE = 256;
   localparam int DEF_MAX_PAGE = 4096;
   localparam int DEF_MAX_STEPS = 64;

   localparam logic [PAD_W-1:0] PAD_RESET = 2'd1;

   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_PAD_WIDTH = 1'b0;

   localparam logic [1:0] CMD_PLACE = 2'd0;
   localparam logic [1:0] CMD_CLEAR = 2'd1;
   localparam logic [1:0] CMD_FLUSH = 2'd2;

   typedef logic [COORD_W-1:0] coord_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SCAN,
      ST_PICK_LOAD,
      ST_PICK,
      ST_GROW,
      ST_FETCH,
      ST_DEL,
      ST_MERGE,
      ST_CAP,
      ST_FIN,
      ST_RESP
   } state_type;

   typedef enum logic [3:0] {
      CELL_HOLD,
      CELL_CLEAR,
      CELL_LOAD,
      CELL_SCAN,
      CELL_PICK_LOAD,
      CELL_SHIFT,
      CELL_GROW,
      CELL_DEL,
      CELL_WRITE,
      CELL_MERGE
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      coord_type   pw;
      coord_type   ph;
      coord_type   page;
      coord_type   x_new;
      coord_type   top;
      coord_type   x1;
      coord_type   tail_h;
      logic        ins2;
   } cell_ctrl_type;

   typedef struct packed {
      coord_type head_x;
      coord_type head_y;
      logic      head_v;
      coord_type k_h;
      coord_type k1_x;
      coord_type k1_h;
      logic      any_eq;
   } chain_status_type;

   typedef struct packed {
      coord_type left;
      coord_type top;
      coord_type right;
      coord_type bottom;
   } box_type;

   function automatic box_type dirty_merge(box_type b, coord_type x0, coord_type y0,
                                           coord_type x1, coord_type y1);
      box_type r;
      if (b.right == '0) begin
         r.left = x0;
         r.top = y0;
         r.right = x1;
         r.bottom = y1;
      end else begin
         r.left = (x0 < b.left) ? x0 : b.left;
         r.top = (y0 < b.top) ? y0 : b.top;
         r.right = (x1 > b.right) ? x1 : b.right;
         r.bottom = (y1 > b.bottom) ? y1 : b.bottom;
      end
      return r;
   endfunction

endpackage

[sv/srp_cell.sv]
// One skyline step cell: holds a step, a probe that travels along the row, and a fit height.
module srp_cell import srp_pkg::*; #(
   parameter int IDX = 0,
   parameter int CW = 7,
   parameter int MIN_PAGE = DEF_MIN_PAGE
) (
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  logic [CW-1:0] count,
   input  logic [CW-1:0] pos,
   input  coord_type     r_sx,
   input  coord_type     r_sh,
   input  coord_type     r_px,
   input  coord_type     r_py,
   input  logic          r_pv,
   input  coord_type     l_sx,
   input  coord_type     l_sh,
   input  logic          del_in,
   output coord_type     sx,
   output coord_type     sh,
   output coord_type     px,
   output coord_type     py,
   output logic          pv,
   output logic          del_out
);

   coord_type sx_ff, sx_in, sh_ff, sh_in, px_ff, px_in, py_ff, py_in, acc_ff, acc_in;
   logic pv_ff, pv_in;
   logic eq, real_step;
   logic [COORD_W:0] reach, acc_top;
   logic [CW-1:0] my_idx, pos_next;

   assign my_idx = CW'(IDX);
   assign pos_next = pos + CW'(1);
   assign real_step = CW'(IDX + 1) < count;
   assign reach = {1'b0, sx_ff} + {1'b0, ctrl.pw};
   assign acc_top = {1'b0, acc_ff} + {1'b0, ctrl.ph};
   assign eq = (IDX != 0) && real_step && (sh_ff == l_sh);
   assign del_out = del_in | eq;

   always_comb begin
      sx_in = sx_ff;
      sh_in = sh_ff;
      px_in = px_ff;
      py_in = py_ff;
      pv_in = pv_ff;
      acc_in = acc_ff;
      case (ctrl.op)
         CELL_CLEAR: begin
            sx_in = (IDX == 1) ? ctrl.page : '0;
            sh_in = '0;
         end
         CELL_LOAD: begin
            px_in = sx_ff;
            py_in = sh_ff;
            pv_in = real_step;
            acc_in = '0;
         end
         CELL_SCAN: begin
            if (pv_ff && ({1'b0, px_ff} < reach) && (py_ff > acc_ff)) begin
               acc_in = py_ff;
            end
            px_in = r_px;
            py_in = r_py;
            pv_in = r_pv;
         end
         CELL_PICK_LOAD: begin
            px_in = sx_ff;
            py_in = acc_ff;
            pv_in = real_step && (reach <= {1'b0, ctrl.page})
                    && (acc_top <= {1'b0, ctrl.page});
         end
         CELL_SHIFT: begin
            px_in = r_px;
            py_in = r_py;
            pv_in = r_pv;
         end
         CELL_GROW: begin
            if (my_idx == count - CW'(1)) begin
               sh_in = '0;
            end
            if (my_idx == count) begin
               sx_in = ctrl.page;
               sh_in = '0;
            end
         end
         CELL_DEL: begin
            if (my_idx >= pos) begin
               sx_in = r_sx;
               sh_in = r_sh;
            end
         end
         CELL_WRITE: begin
            if (my_idx == pos) begin
               sx_in = ctrl.x_new;
               sh_in = ctrl.top;
            end else if (ctrl.ins2 && (my_idx == pos_next)) begin
               sx_in = ctrl.x1;
               sh_in = ctrl.tail_h;
            end else if (ctrl.ins2 && (my_idx > pos_next)) begin
               sx_in = l_sx;
               sh_in = l_sh;
            end
         end
         CELL_MERGE: begin
            if (del_out) begin
               sx_in = r_sx;
               sh_in = r_sh;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sx_ff <= (IDX == 1) ? COORD_W'(MIN_PAGE) : '0;
         sh_ff <= '0;
         pv_ff <= 1'b0;
      end else begin
         sx_ff <= sx_in;
         sh_ff <= sh_in;
         pv_ff <= pv_in;
         px_ff <= px_in;
         py_ff <= py_in;
         acc_ff <= acc_in;
      end
   end

   assign sx = sx_ff;
   assign sh = sh_ff;
   assign px = px_ff;
   assign py = py_ff;
   assign pv = pv_ff;

endmodule

[sv/srp_seq.sv]
// Command sequencer of the skyline packer: search passes, page growth, rewrite and result register.
module srp_seq import srp_pkg::*; #(
   parameter int MIN_PAGE = DEF_MIN_PAGE,
   parameter int MAX_PAGE = DEF_MAX_PAGE,
   parameter int MAX_STEPS = DEF_MAX_STEPS,
   parameter int IW = $clog2(MAX_STEPS),
   parameter int CW = $clog2(MAX_STEPS + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [PAD_W-1:0]  pad,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_cmd,
   input  logic [SIZE_W-1:0] req_rect_width,
   input  logic [SIZE_W-1:0] req_rect_height,
   input  chain_status_type  status,
   output cell_ctrl_type     cell_ctrl,
   output logic [CW-1:0]     count,
   output logic [CW-1:0]     pos,
   output logic [IW-1:0]     best_i,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_ok,
   output coord_type         rsp_pos_x,
   output coord_type         rsp_pos_y,
   output coord_type         rsp_page_side,
   output logic [AREA_W-1:0] rsp_area_used,
   output logic              rsp_dirty_valid,
   output coord_type         rsp_dirty_left,
   output coord_type         rsp_dirty_top,
   output coord_type         rsp_dirty_right,
   output coord_type         rsp_dirty_bottom
);

   localparam logic [IW-1:0] T_LAST = IW'(MAX_STEPS - 1);
   localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_STEPS);
   localparam coord_type MAX_SIDE = COORD_W'(MAX_PAGE);

   state_type state_ff, state_in;
   logic [IW-1:0] t_ff, t_in, best_i_ff, best_i_in;
   logic [CW-1:0] count_ff, count_in;
   coord_type pw_ff, pw_in, ph_ff, ph_in, page_ff, page_in;
   coord_type best_x_ff, best_x_in, best_y_ff, best_y_in;
   coord_type x1_ff, x1_in, tail_h_ff, tail_h_in;
   coord_type px_res_ff, px_res_in, py_res_ff, py_res_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [AREA_W-1:0] cap_ff, cap_in, used_ff, used_in;
   box_type dirty_ff, dirty_in, dres_ff, dres_in;
   logic ok_ff, ok_in, dv_ff, dv_in;
   logic accept, rsp_free, grow_ok, found, longer, wider;
   logic [COORD_W:0] dbl;
   coord_type new_side;
   logic [2*COORD_W-1:0] side_sq;
   logic [AREA_W:0] area_sum;

   logic rsp_valid_ff, rsp_ok_ff, rsp_dv_ff;
   coord_type rsp_px_ff, rsp_py_ff, rsp_page_ff;
   logic [AREA_W-1:0] rsp_area_ff;
   box_type rsp_d_ff;

   assign accept = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign found = best_y_ff < page_ff;
   assign grow_ok = (page_ff < MAX_SIDE) && (count_ff < COUNT_FULL);
   assign dbl = {page_ff, 1'b0};
   assign new_side = (dbl > {1'b0, MAX_SIDE}) ? MAX_SIDE : dbl[COORD_W-1:0];
   assign longer = status.k1_x < x1_ff;
   assign wider = status.k1_x > x1_ff;
   assign side_sq = page_ff * page_ff;
   assign area_sum = {1'b0, used_ff} + {{(AREA_W + 1 - PROD_W){1'b0}}, prod_ff};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if ((req_cmd == CMD_PLACE) && (req_rect_width != '0)
                   && (req_rect_height != '0)) begin
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_LOAD: state_in = ST_SCAN;
         ST_SCAN: if (t_ff == T_LAST) state_in = ST_PICK_LOAD;
         ST_PICK_LOAD: state_in = ST_PICK;
         ST_PICK: if (t_ff == T_LAST) state_in = ST_GROW;
         ST_GROW: begin
            if (found) begin
               state_in = ST_FETCH;
            end else if (grow_ok) begin
               state_in = ST_LOAD;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_FETCH: state_in = ST_DEL;
         ST_DEL: begin
            if (!longer) begin
               state_in = (wider && (count_ff == COUNT_FULL)) ? ST_RESP : ST_MERGE;
            end
         end
         ST_MERGE: if (!status.any_eq) state_in = ST_CAP;
         ST_CAP: state_in = ST_FIN;
         ST_FIN: state_in = ST_RESP;
         ST_RESP: if (rsp_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      t_in = t_ff;
      best_i_in = best_i_ff;
      count_in = count_ff;
      pw_in = pw_ff;
      ph_in = ph_ff;
      page_in = page_ff;
      best_x_in = best_x_ff;
      best_y_in = best_y_ff;
      x1_in = x1_ff;
      tail_h_in = tail_h_ff;
      px_res_in = px_res_ff;
      py_res_in = py_res_ff;
      prod_in = prod_ff;
      cap_in = cap_ff;
      used_in = used_ff;
      dirty_in = dirty_ff;
      dres_in = dres_ff;
      ok_in = ok_ff;
      dv_in = dv_ff;
      pos = '0;
      cell_ctrl.op = CELL_HOLD;
      cell_ctrl.pw = pw_ff;
      cell_ctrl.ph = ph_ff;
      cell_ctrl.page = page_ff;
      cell_ctrl.x_new = best_x_ff;
      cell_ctrl.top = best_y_ff + ph_ff;
      cell_ctrl.x1 = x1_ff;
      cell_ctrl.tail_h = tail_h_ff;
      cell_ctrl.ins2 = wider;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pw_in = COORD_W'(req_rect_width) + COORD_W'({pad, 1'b0});
               ph_in = COORD_W'(req_rect_height) + COORD_W'({pad, 1'b0});
               prod_in = req_rect_width * req_rect_height;
               ok_in = 1'b0;
               dv_in = 1'b0;
               dres_in = '0;
               px_res_in = '0;
               py_res_in = '0;
               case (req_cmd)
                  CMD_CLEAR: begin
                     cell_ctrl.op = CELL_CLEAR;
                     count_in = CW'(2);
                     used_in = '0;
                     dirty_in = dirty_merge(dirty_ff, '0, '0, page_ff, page_ff);
                     ok_in = 1'b1;
                  end
                  CMD_FLUSH: begin
                     ok_in = 1'b1;
                     if (dirty_ff.right != '0) begin
                        dv_in = 1'b1;
                        dres_in = dirty_ff;
                        dirty_in.right = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LOAD: begin
            cell_ctrl.op = CELL_LOAD;
            t_in = '0;
         end
         ST_SCAN: begin
            cell_ctrl.op = CELL_SCAN;
            t_in = t_ff + IW'(1);
         end
         ST_PICK_LOAD: begin
            cell_ctrl.op = CELL_PICK_LOAD;
            best_y_in = page_ff;
            t_in = '0;
         end
         ST_PICK: begin
            cell_ctrl.op = CELL_SHIFT;
            t_in = t_ff + IW'(1);
            if (status.head_v && (status.head_y < best_y_ff)) begin
               best_y_in = status.head_y;
               best_x_in = status.head_x;
               best_i_in = t_ff;
            end
         end
         ST_GROW: begin
            if (!found && grow_ok) begin
               cell_ctrl.op = CELL_GROW;
               cell_ctrl.page = new_side;
               page_in = new_side;
               count_in = count_ff + CW'(1);
               dirty_in = dirty_merge(dirty_ff, '0, '0, new_side, new_side);
            end
         end
         ST_FETCH: begin
            tail_h_in = status.k_h;
            x1_in = best_x_ff + pw_ff;
         end
         ST_DEL: begin
            if (longer) begin
               tail_h_in = status.k1_h;
               cell_ctrl.op = CELL_DEL;
               pos = CW'(best_i_ff) + CW'(1);
               count_in = count_ff - CW'(1);
            end else if (!(wider && (count_ff == COUNT_FULL))) begin
               cell_ctrl.op = CELL_WRITE;
               pos = CW'(best_i_ff);
               count_in = count_ff + CW'(wider);
            end
         end
         ST_MERGE: begin
            cell_ctrl.op = CELL_MERGE;
            if (status.any_eq) begin
               count_in = count_ff - CW'(1);
            end
         end
         ST_CAP: begin
            cap_in = AREA_W'(side_sq);
         end
         ST_FIN: begin
            used_in = (area_sum > {1'b0, cap_ff}) ? cap_ff : area_sum[AREA_W-1:0];
            dirty_in = dirty_merge(dirty_ff, best_x_ff, best_y_ff, best_x_ff + pw_ff,
                                   best_y_ff + ph_ff);
            ok_in = 1'b1;
            px_res_in = best_x_ff + COORD_W'(pad);
            py_res_in = best_y_ff + COORD_W'(pad);
         end
         ST_RESP: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= CW'(2);
         page_ff <= COORD_W'(MIN_PAGE);
         used_ff <= '0;
         dirty_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         page_ff <= page_in;
         used_ff <= used_in;
         dirty_ff <= dirty_in;
         if ((state_ff == ST_RESP) && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      t_ff <= t_in;
      best_i_ff <= best_i_in;
      pw_ff <= pw_in;
      ph_ff <= ph_in;
      best_x_ff <= best_x_in;
      best_y_ff <= best_y_in;
      x1_ff <= x1_in;
      tail_h_ff <= tail_h_in;
      px_res_ff <= px_res_in;
      py_res_ff <= py_res_in;
      prod_ff <= prod_in;
      cap_ff <= cap_in;
      dres_ff <= dres_in;
      ok_ff <= ok_in;
      dv_ff <= dv_in;
      if ((state_ff == ST_RESP) && rsp_free) begin
         rsp_ok_ff <= ok_ff;
         rsp_px_ff <= px_res_ff;
         rsp_py_ff <= py_res_ff;
         rsp_page_ff <= page_ff;
         rsp_area_ff <= used_ff;
         rsp_dv_ff <= dv_ff;
         rsp_d_ff <= dres_ff;
      end
   end

   assign count = count_ff;
   assign best_i = best_i_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_ok = rsp_ok_ff;
   assign rsp_pos_x = rsp_px_ff;
   assign rsp_pos_y = rsp_py_ff;
   assign rsp_page_side = rsp_page_ff;
   assign rsp_area_used = rsp_area_ff;
   assign rsp_dirty_valid = rsp_dv_ff;
   assign rsp_dirty_left = rsp_d_ff.left;
   assign rsp_dirty_top = rsp_d_ff.top;
   assign rsp_dirty_right = rsp_d_ff.right;
   assign rsp_dirty_bottom = rsp_d_ff.bottom;

endmodule

[sv/skyline_rect_packer.sv]
// Skyline rectangle packer top level: a row of MAX_STEPS step cells, each holding one step of
// the skyline, run by a command sequencer, with a register port for the padding. One command is
// handled at a time. A place runs one search pass (probes travel the whole row of cells to find
// each start's fit height, then the fit heights travel to the head where the lowest, leftmost
// one is kept), one more pass for every page doubling, and then a rewrite that deletes every
// step beyond the first that the new rectangle covers and removes a step wherever neighbouring
// heights are equal and must be merged. A result waits in an output register.
module skyline_rect_packer import srp_pkg::*; #(
   parameter int MIN_PAGE = DEF_MIN_PAGE,
   parameter int MAX_PAGE = DEF_MAX_PAGE,
   parameter int MAX_STEPS = DEF_MAX_STEPS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_cmd,
   input  logic [SIZE_W-1:0]     req_rect_width,
   input  logic [SIZE_W-1:0]     req_rect_height,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_ok,
   output coord_type             rsp_pos_x,
   output coord_type             rsp_pos_y,
   output coord_type             rsp_page_side,
   output logic [AREA_W-1:0]     rsp_area_used,
   output logic                  rsp_dirty_valid,
   output coord_type             rsp_dirty_left,
   output coord_type             rsp_dirty_top,
   output coord_type             rsp_dirty_right,
   output coord_type             rsp_dirty_bottom
);

   localparam int IW = $clog2(MAX_STEPS);
   localparam int CW = $clog2(MAX_STEPS + 1);

   logic [PAD_W-1:0] pad_ff;
   cell_ctrl_type cell_ctrl;
   chain_status_type status;
   logic [CW-1:0] count, pos;
   logic [IW-1:0] best_i, k1;

   coord_type cell_sx [MAX_STEPS];
   coord_type cell_sh [MAX_STEPS];
   coord_type cell_px [MAX_STEPS];
   coord_type cell_py [MAX_STEPS];
   logic cell_pv [MAX_STEPS];
   logic cell_del [MAX_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_ff <= PAD_RESET;
      end else if (psel && penable && pwrite && (paddr[2] == CSR_IDX_PAD_WIDTH)) begin
         pad_ff <= pwdata[PAD_W-1:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == CSR_IDX_PAD_WIDTH) ? {{(32 - PAD_W){1'b0}}, pad_ff} : '0;

   genvar j;
   generate
      for (j = 0; j < MAX_STEPS; j++) begin : g_cell
         coord_type r_sx, r_sh, r_px, r_py, l_sx, l_sh;
         logic r_pv, del_in;
         if (j == MAX_STEPS - 1) begin : g_last
            assign r_sx = '0;
            assign r_sh = '0;
            assign r_px = '0;
            assign r_py = '0;
            assign r_pv = 1'b0;
         end else begin : g_mid
            assign r_sx = cell_sx[j+1];
            assign r_sh = cell_sh[j+1];
            assign r_px = cell_px[j+1];
            assign r_py = cell_py[j+1];
            assign r_pv = cell_pv[j+1];
         end
         if (j == 0) begin : g_first
            assign l_sx = '0;
            assign l_sh = '0;
            assign del_in = 1'b0;
         end else begin : g_left
            assign l_sx = cell_sx[j-1];
            assign l_sh = cell_sh[j-1];
            assign del_in = cell_del[j-1];
         end
         srp_cell #(
            .IDX(j),
            .CW(CW),
            .MIN_PAGE(MIN_PAGE)
         ) u_cell (
            .clock(clock),
            .reset(reset),
            .ctrl(cell_ctrl),
            .count(count),
            .pos(pos),
            .r_sx(r_sx),
            .r_sh(r_sh),
            .r_px(r_px),
            .r_py(r_py),
            .r_pv(r_pv),
            .l_sx(l_sx),
            .l_sh(l_sh),
            .del_in(del_in),
            .sx(cell_sx[j]),
            .sh(cell_sh[j]),
            .px(cell_px[j]),
            .py(cell_py[j]),
            .pv(cell_pv[j]),
            .del_out(cell_del[j])
         );
      end
   endgenerate

   assign k1 = best_i + IW'(1);
   assign status.head_x = cell_px[0];
   assign status.head_y = cell_py[0];
   assign status.head_v = cell_pv[0];
   assign status.k_h = cell_sh[best_i];
   assign status.k1_x = cell_sx[k1];
   assign status.k1_h = cell_sh[k1];
   assign status.any_eq = cell_del[MAX_STEPS-1];

   srp_seq #(
      .MIN_PAGE(MIN_PAGE),
      .MAX_PAGE(MAX_PAGE),
      .MAX_STEPS(MAX_STEPS),
      .IW(IW),
      .CW(CW)
   ) u_seq (
      .clock(clock),
      .reset(reset),
      .pad(pad_ff),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_rect_width(req_rect_width),
      .req_rect_height(req_rect_height),
      .status(status),
      .cell_ctrl(cell_ctrl),
      .count(count),
      .pos(pos),
      .best_i(best_i),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_ok(rsp_ok),
      .rsp_pos_x(rsp_pos_x),
      .rsp_pos_y(rsp_pos_y),
      .rsp_page_side(rsp_page_side),
      .rsp_area_used(rsp_area_used),
      .rsp_dirty_valid(rsp_dirty_valid),
      .rsp_dirty_left(rsp_dirty_left),
      .rsp_dirty_top(rsp_dirty_top),
      .rsp_dirty_right(rsp_dirty_right),
      .rsp_dirty_bottom(rsp_dirty_bottom)
   );

endmodule

[sv/srp_checker.sv]
// Port-level checker of the skyline packer and its bind to the top level.
`include "skyline_rect_packer_macros.svh"

module srp_checker import srp_pkg::*; (
   input logic      clock,
   input logic      reset,
   input logic      req_valid,
   input logic      req_stall,
   input logic      rsp_valid,
   input logic      rsp_stall,
   input logic      rsp_ok,
   input coord_type rsp_pos_x,
   input coord_type rsp_pos_y,
   input logic      rsp_dirty_valid,
   input coord_type rsp_dirty_left,
   input coord_type rsp_dirty_top,
   input coord_type rsp_dirty_right,
   input coord_type rsp_dirty_bottom
);

   // A failed command, an unknown or empty one included, reports no position.
   `SRP_ASSERT_NOW(a_fail_no_pos, rsp_valid && !rsp_ok, (rsp_pos_x == '0) && (rsp_pos_y == '0))

   // Without a dirty region all four dirty fields read as zero.
   `SRP_ASSERT_NOW(a_clean_box, rsp_valid && !rsp_dirty_valid, (rsp_dirty_left == '0) && (rsp_dirty_top == '0) && (rsp_dirty_right == '0) && (rsp_dirty_bottom == '0))

   // A reported dirty region is never empty.
   `SRP_ASSERT_NOW(a_dirty_nonempty, rsp_valid && rsp_dirty_valid, rsp_ok && (rsp_dirty_right != '0))

   // One command at a time: the input stalls right after a transfer.
   `SRP_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall)

   // A stalled result stays on offer.
   `SRP_ASSERT_NEXT(a_rsp_holds, rsp_valid && rsp_stall, rsp_valid)

endmodule

bind skyline_rect_packer srp_checker u_srp_checker (.*);

[sim/skyline_rect_packer_tb.sv]
// Self-checking testbench for the skyline rectangle packer: directed and random commands.
module skyline_rect_packer_tb;
   import srp_pkg::*;

   localparam logic [1:0] CMD_UNKNOWN = 2'd3;
   localparam int NUM_STEPS = DEF_MAX_STEPS;
   localparam int RANDOM_PER_PHASE = 350;

   typedef struct packed {
      logic              ok;
      coord_type         pos_x;
      coord_type         pos_y;
      coord_type         page_side;
      logic [AREA_W-1:0] area_used;
      logic              dirty_valid;
      coord_type         dirty_left;
      coord_type         dirty_top;
      coord_type         dirty_right;
      coord_type         dirty_bottom;
   } outcome_type;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [SIZE_W-1:0] width;
      logic [SIZE_W-1:0] height;
      logic              typed;
      outcome_type       outcome;
   } row_type;

   logic                  clock;
   logic                  reset;
   logic                  psel, penable, pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0]           pwdata;
   logic [31:0]           prdata;
   logic                  pready;
   logic                  req_valid, req_stall;
   logic [1:0]            req_cmd;
   logic [SIZE_W-1:0]     req_rect_width, req_rect_height;
   logic                  rsp_valid, rsp_stall;
   outcome_type           got;

   skyline_rect_packer dut (
      .clock(clock), .reset(reset),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready),
      .req_valid(req_valid), .req_stall(req_stall), .req_cmd(req_cmd),
      .req_rect_width(req_rect_width), .req_rect_height(req_rect_height),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_ok(got.ok),
      .rsp_pos_x(got.pos_x), .rsp_pos_y(got.pos_y), .rsp_page_side(got.page_side),
      .rsp_area_used(got.area_used), .rsp_dirty_valid(got.dirty_valid),
      .rsp_dirty_left(got.dirty_left), .rsp_dirty_top(got.dirty_top),
      .rsp_dirty_right(got.dirty_right), .rsp_dirty_bottom(got.dirty_bottom)
   );

   // Packer state as predicted.
   int unsigned pad;
   int unsigned sky_x[NUM_STEPS];
   int unsigned sky_h[NUM_STEPS];
   int unsigned sky_count;
   int unsigned page;
   int unsigned area_sum;
   box_type     dirty;

   outcome_type pending_outcomes[$];
   int          mismatches;
   int          burst_left, gap_left;
   int          stall_mode, stall_left;
   row_type     rows[20];

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #100000000;
      $display("** skyline_rect_packer: FAILED **");
      $finish;
   end

   function automatic void add_dirty(int unsigned x0, int unsigned y0, int unsigned x1,
                                     int unsigned y1);
      if (dirty.right == '0) begin
         dirty.left = COORD_W'(x0);
         dirty.top = COORD_W'(y0);
         dirty.right = COORD_W'(x1);
         dirty.bottom = COORD_W'(y1);
      end else begin
         if (x0 < dirty.left) dirty.left = COORD_W'(x0);
         if (y0 < dirty.top) dirty.top = COORD_W'(y0);
         if (x1 > dirty.right) dirty.right = COORD_W'(x1);
         if (y1 > dirty.bottom) dirty.bottom = COORD_W'(y1);
      end
   endfunction

   function automatic void empty_skyline();
      for (int i = 0; i < NUM_STEPS; i++) begin
         sky_x[i] = 0;
         sky_h[i] = 0;
      end
      sky_count = 2;
      sky_x[1] = page;
      area_sum = 0;
   endfunction

   function automatic bit double_page();
      int unsigned ns;
      if (page >= DEF_MAX_PAGE) return 1'b0;
      if (sky_count >= NUM_STEPS || sky_count < 1) return 1'b0;
      ns = (page * 2 < DEF_MAX_PAGE) ? page * 2 : DEF_MAX_PAGE;
      page = ns;
      sky_h[sky_count-1] = 0;
      sky_x[sky_count] = ns;
      sky_h[sky_count] = 0;
      sky_count++;
      add_dirty(0, 0, ns, ns);
      return 1'b1;
   endfunction

   function automatic int unsigned lowest_top(int unsigned k, int unsigned pw, int unsigned ph);
      int unsigned x, y;
      x = sky_x[k];
      y = 0;
      if (x + pw > page) return page;
      for (int unsigned i = k; i + 1 < sky_count && sky_x[i] < x + pw; i++)
         if (sky_h[i] > y) y = sky_h[i];
      if (y + ph > page) return page;
      return y;
   endfunction

   function automatic bit raise_steps(int unsigned k, int unsigned top, int unsigned pw);
      int unsigned x, x1, last, tail_h, ins, newc, w;
      int unsigned tx[NUM_STEPS];
      int unsigned th[NUM_STEPS];
      x = sky_x[k];
      x1 = x + pw;
      last = k;
      while (last + 1 < sky_count && sky_x[last] < x1) last++;
      if (last <= k) return 1'b0;
      tail_h = sky_h[last-1];
      ins = (sky_x[last] > x1) ? 2 : 1;
      newc = sky_count + ins - (last - k);
      if (newc > NUM_STEPS) return 1'b0;
      tx = sky_x;
      th = sky_h;
      for (int unsigned i = 0; i < sky_count - last; i++) begin
         sky_x[k+ins+i] = tx[last+i];
         sky_h[k+ins+i] = th[last+i];
      end
      sky_x[k] = x;
      sky_h[k] = top;
      if (ins == 2) begin
         sky_x[k+1] = x1;
         sky_h[k+1] = tail_h;
      end
      sky_count = newc;
      w = 1;
      for (int unsigned i = 1; i + 1 < sky_count; i++) begin
         if (sky_h[i] != sky_h[w-1]) begin
            sky_x[w] = sky_x[i];
            sky_h[w] = sky_h[i];
            w++;
         end
      end
      sky_x[w] = sky_x[sky_count-1];
      sky_h[w] = sky_h[sky_count-1];
      sky_count = w + 1;
      return 1'b1;
   endfunction

   function automatic bit place_rect(int unsigned wd, int unsigned ht, output int unsigned px,
                                     output int unsigned py);
      int unsigned pw, ph, best_i, best_x, best_y, y;
      longint unsigned sum, cap;
      pw = wd + 2 * pad;
      ph = ht + 2 * pad;
      best_i = 0;
      best_x = 0;
      px = 0;
      py = 0;
      if (wd == 0 || ht == 0) return 1'b0;
      forever begin
         best_y = page;
         for (int unsigned i = 0; i + 1 < sky_count; i++) begin
            y = lowest_top(i, pw, ph);
            if (y < best_y) begin
               best_y = y;
               best_x = sky_x[i];
               best_i = i;
            end
         end
         if (best_y < page) break;
         if (!double_page()) return 1'b0;
      end
      if (!raise_steps(best_i, best_y + ph, pw)) return 1'b0;
      sum = longint'(area_sum) + longint'(wd) * longint'(ht);
      cap = longint'(page) * longint'(page);
      area_sum = 32'((sum < cap) ? sum : cap);
      add_dirty(best_x, best_y, best_x + pw, best_y + ph);
      px = best_x + pad;
      py = best_y + pad;
      return 1'b1;
   endfunction

   function automatic outcome_type predict_command(logic [1:0] cmd, int unsigned wd,
                                                   int unsigned ht);
      outcome_type o;
      int unsigned px, py;
      o = '0;
      if (cmd == CMD_PLACE) begin
         o.ok = place_rect(wd, ht, px, py);
         if (o.ok) begin
            o.pos_x = COORD_W'(px);
            o.pos_y = COORD_W'(py);
         end
      end else if (cmd == CMD_CLEAR) begin
         empty_skyline();
         add_dirty(0, 0, page, page);
         o.ok = 1'b1;
      end else if (cmd == CMD_FLUSH) begin
         o.ok = 1'b1;
         if (dirty.right != '0) begin
            o.dirty_valid = 1'b1;
            o.dirty_left = dirty.left;
            o.dirty_top = dirty.top;
            o.dirty_right = dirty.right;
            o.dirty_bottom = dirty.bottom;
            dirty.right = '0;
         end
      end
      o.page_side = COORD_W'(page);
      o.area_used = AREA_W'(area_sum);
      return o;
   endfunction

   task automatic send_command(logic [1:0] cmd, logic [SIZE_W-1:0] wd, logic [SIZE_W-1:0] ht,
                               logic typed, outcome_type typed_outcome);
      outcome_type o;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
      end
      while (gap_left > 0) begin
         req_valid = 1'b0;
         @(negedge clock);
         gap_left--;
      end
      req_valid = 1'b1;
      req_cmd = cmd;
      req_rect_width = wd;
      req_rect_height = ht;
      do @(posedge clock); while (req_stall);
      o = predict_command(cmd, wd, ht);
      pending_outcomes.push_back(typed ? typed_outcome : o);
      burst_left--;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (pending_outcomes.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_pad(int unsigned value);
      psel = 1'b1;
      pwrite = 1'b1;
      penable = 1'b0;
      paddr = {CSR_IDX_PAD_WIDTH, 2'b00};
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      pwrite = 1'b0;
      penable = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      if (prdata[PAD_W-1:0] !== value[PAD_W-1:0]) begin
         mismatches++;
         $display("pad_width readback: expected %0d, got %0d", value, prdata);
      end
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pad = value;
   endtask

   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(20, 300);
      end
      stall_left <= stall_left - 1;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= 1'($urandom_range(0, 1));
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transfer: %p", got);
         end else begin
            if (got !== pending_outcomes[0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result mismatch:\n  expected %p\n  actual   %p",
                           pending_outcomes[0], got);
            end
            void'(pending_outcomes.pop_front());
         end
      end
   end

   initial begin
      logic [1:0]        cmd;
      logic [SIZE_W-1:0] wd, ht;
      int unsigned       pick;
      int unsigned       pad_plan[4];
      rows[0]  = '{CMD_FLUSH, 0, 0, 1, '{1, 0, 0, 256, 0, 0, 0, 0, 0, 0}};
      rows[1]  = '{CMD_PLACE, 10, 10, 1, '{1, 1, 1, 256, 100, 0, 0, 0, 0, 0}};
      rows[2]  = '{CMD_PLACE, 0, 5, 1, '{0, 0, 0, 256, 100, 0, 0, 0, 0, 0}};
      rows[3]  = '{CMD_PLACE, 5, 0, 1, '{0, 0, 0, 256, 100, 0, 0, 0, 0, 0}};
      rows[4]  = '{CMD_UNKNOWN, 4095, 4095, 1, '{0, 0, 0, 256, 100, 0, 0, 0, 0, 0}};
      rows[5]  = '{CMD_FLUSH, 0, 0, 1, '{1, 0, 0, 256, 100, 1, 0, 0, 12, 12}};
      rows[6]  = '{CMD_PLACE, 4095, 4095, 0, '0};
      rows[7]  = '{CMD_PLACE, 4094, 1, 0, '0};
      rows[8]  = '{CMD_PLACE, 1, 4094, 0, '0};
      rows[9]  = '{CMD_PLACE, 1, 1, 0, '0};
      rows[10] = '{CMD_FLUSH, 0, 0, 0, '0};
      rows[11] = '{CMD_CLEAR, 7, 9, 1, '{1, 0, 0, 4096, 0, 0, 0, 0, 0, 0}};
      rows[12] = '{CMD_PLACE, 4094, 4094, 1, '{1, 1, 1, 4096, 16760836, 0, 0, 0, 0, 0}};
      rows[13] = '{CMD_PLACE, 1, 1, 1, '{0, 0, 0, 4096, 16760836, 0, 0, 0, 0, 0}};
      rows[14] = '{CMD_FLUSH, 0, 0, 1, '{1, 0, 0, 4096, 16760836, 1, 0, 0, 4096, 4096}};
      rows[15] = '{CMD_CLEAR, 0, 0, 0, '0};
      rows[16] = '{CMD_PLACE, 2048, 1, 0, '0};
      rows[17] = '{CMD_PLACE, 2048, 1, 0, '0};
      rows[18] = '{CMD_PLACE, 2730, 3000, 0, '0};
      rows[19] = '{CMD_FLUSH, 0, 0, 0, '0};
      pad_plan = '{0, 3, 2, 1};

      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_valid = 1'b0;
      req_cmd = CMD_PLACE;
      req_rect_width = '0;
      req_rect_height = '0;
      rsp_stall = 1'b0;
      stall_mode = 0;
      stall_left = 0;
      burst_left = 0;
      gap_left = 0;
      mismatches = 0;
      pad = PAD_RESET;
      page = DEF_MIN_PAGE;
      empty_skyline();
      dirty = '0;
      repeat (8) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      foreach (rows[r])
         send_command(rows[r].cmd, rows[r].width, rows[r].height, rows[r].typed,
                      rows[r].outcome);

      foreach (pad_plan[p]) begin
         wait_drained();
         write_pad(pad_plan[p]);
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            pick = $urandom_range(0, 99);
            cmd = (pick < 85) ? CMD_PLACE : (pick < 93) ? CMD_FLUSH :
                  (pick < 98) ? CMD_CLEAR : CMD_UNKNOWN;
            pick = $urandom_range(0, 99);
            wd = SIZE_W'((pick < 2) ? 0 : (pick < 72) ? $urandom_range(1, 48) :
                 (pick < 92) ? $urandom_range(1, 512) : $urandom_range(1, 4095));
            pick = $urandom_range(0, 99);
            ht = SIZE_W'((pick < 2) ? 0 : (pick < 72) ? $urandom_range(1, 48) :
                 (pick < 92) ? $urandom_range(1, 512) : $urandom_range(1, 4095));
            send_command(cmd, wd, ht, 1'b0, '0);
         end
      end

      req_valid = 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatches == 0 && pending_outcomes.size() == 0)
         $display("** skyline_rect_packer: PASSED **");
      else
         $display("** skyline_rect_packer: FAILED **");
      $finish;
   end

endmodule
